@@ src/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock set controller package
// Shared types, codes, field limits and BCD conversion functions.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int FIELD_COUNT = 7;
   localparam int VALUE_W     = 7;
   localparam int IDLE_W      = 17;
   localparam int LIMIT_W     = 16;

   localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 16'd10000;

   typedef enum logic [2:0] {
      KIND_START = 3'd0,
      KIND_NONE  = 3'd1,
      KIND_UP    = 3'd2,
      KIND_DOWN  = 3'd3,
      KIND_ENTER = 3'd4
   } kind_type;

   localparam logic [2:0] FIELD_YEAR    = 3'd0;
   localparam logic [2:0] FIELD_MONTH   = 3'd1;
   localparam logic [2:0] FIELD_DAY     = 3'd2;
   localparam logic [2:0] FIELD_WEEKDAY = 3'd3;
   localparam logic [2:0] FIELD_HOUR    = 3'd4;
   localparam logic [2:0] FIELD_MINUTE  = 3'd5;
   localparam logic [2:0] FIELD_SECOND  = 3'd6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  load_year_bcd;
      logic [15:0] load_month_day_bcd;
      logic [15:0] load_weekday_hour_bcd;
      logic [15:0] load_minute_second_bcd;
   } item_type;

   typedef struct packed {
      logic [7:0]  year_bcd;
      logic [12:0] month_day_bcd;
      logic [10:0] weekday_hour_bcd;
      logic [14:0] minute_second_bcd;
      logic [2:0]  field_selected;
      logic        session_active;
      logic        finished;
   } result_type;

   function automatic logic [VALUE_W-1:0] field_low(input logic [2:0] sel);
      logic [VALUE_W-1:0] lo;
      unique case (sel)
         FIELD_MONTH, FIELD_DAY: lo = 7'd1;
         default:                lo = 7'd0;
      endcase
      return lo;
   endfunction

   function automatic logic [VALUE_W-1:0] field_high(input logic [2:0] sel);
      logic [VALUE_W-1:0] hi;
      unique case (sel)
         FIELD_YEAR:                hi = 7'd99;
         FIELD_MONTH:               hi = 7'd12;
         FIELD_DAY:                 hi = 7'd31;
         FIELD_WEEKDAY:             hi = 7'd6;
         FIELD_HOUR:                hi = 7'd23;
         FIELD_MINUTE, FIELD_SECOND: hi = 7'd59;
         default:                   hi = 7'd0;
      endcase
      return hi;
   endfunction

   // High nibble times ten plus low nibble, without range checking.
   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      logic [7:0] tens8;
      logic [7:0] tens2;
      tens8 = {1'b0, b[7:4], 3'b000};
      tens2 = {3'b000, b[7:4], 1'b0};
      return tens8 + tens2 + {4'b0000, b[3:0]};
   endfunction

   function automatic logic [VALUE_W-1:0] load_value(input logic [2:0] sel,
                                                     input logic [7:0] b);
      logic [7:0] dec;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      dec = bcd_decode(b);
      lo  = field_low(sel);
      hi  = field_high(sel);
      if ((dec > {1'b0, hi}) || (dec < {1'b0, lo})) begin
         return lo;
      end
      return dec[VALUE_W-1:0];
   endfunction

   // Tens found by multiplying with 205/2048, exact for values below 100.
   function automatic logic [7:0] bin_to_bcd(input logic [VALUE_W-1:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {8'd0, v} * 15'd205;
      tens = prod[14:11];
      ones = v - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
      return {tens, ones[3:0]};
   endfunction

endpackage

@@ src/bcd_clock_set_controller_unit.sv @@
// ----------------------------------------------------------------------------
// BCD clock set controller
// Path: each item passes the input register, then the output register.
// Throughput: one item per cycle while the output is not stalled; a stalled
// result lets the input register take one more item, then the input stalls.
// Reset: synchronous, active high; fields return to their lowest values, no
// session is open and the timeout limit returns to 10000.
// ----------------------------------------------------------------------------
module bcd_clock_set_controller_unit
   import csc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_load_year_bcd,
   input  logic [15:0] req_load_month_day_bcd,
   input  logic [15:0] req_load_weekday_hour_bcd,
   input  logic [15:0] req_load_minute_second_bcd,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_year_bcd,
   output logic [12:0] rsp_month_day_bcd,
   output logic [10:0] rsp_weekday_hour_bcd,
   output logic [14:0] rsp_minute_second_bcd,
   output logic [2:0]  rsp_field_selected,
   output logic        rsp_session_active,
   output logic        rsp_finished,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic               in_valid_ff, in_valid_in;
   item_type           item_ff,     item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff,      rsp_in;
   logic [LIMIT_W-1:0] limit_ff,    limit_in;

   logic       req_accept;
   logic       out_busy;
   logic       step_en;
   result_type core_result;

   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign step_en    = in_valid_ff && !out_busy;
   assign req_stall  = in_valid_ff && out_busy;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !step_en);
      item_in      = req_accept ? {req_kind, req_load_year_bcd, req_load_month_day_bcd,
                                   req_load_weekday_hour_bcd,
                                   req_load_minute_second_bcd} : item_ff;
      rsp_valid_in = step_en || out_busy;
      rsp_in       = step_en ? core_result : rsp_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
   end

   csc_edit_core u_edit_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .item          (item_ff),
      .timeout_limit (limit_ff),
      .result        (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_year_bcd          = rsp_ff.year_bcd;
   assign rsp_month_day_bcd     = rsp_ff.month_day_bcd;
   assign rsp_weekday_hour_bcd  = rsp_ff.weekday_hour_bcd;
   assign rsp_minute_second_bcd = rsp_ff.minute_second_bcd;
   assign rsp_field_selected    = rsp_ff.field_selected;
   assign rsp_session_active    = rsp_ff.session_active;
   assign rsp_finished          = rsp_ff.finished;

   a_finished_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.finished |-> !rsp_ff.session_active)
      else $error("finished result shows an open session");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("processed item left no result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with free space");

   a_field_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.field_selected != 3'd7)
      else $error("selected field out of range");

endmodule

@@ src/csc_edit_core.sv @@
// ----------------------------------------------------------------------------
// Clock set controller edit core
// Holds the time fields and session state and applies one item per step.
// ----------------------------------------------------------------------------
module csc_edit_core
   import csc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  item_type           item,
   input  logic [LIMIT_W-1:0] timeout_limit,
   output result_type         result
);

   logic [6:0]        year_ff,    year_in;
   logic [3:0]        month_ff,   month_in;
   logic [4:0]        day_ff,     day_in;
   logic [2:0]        weekday_ff, weekday_in;
   logic [4:0]        hour_ff,    hour_in;
   logic [5:0]        minute_ff,  minute_in;
   logic [5:0]        second_ff,  second_in;
   logic [2:0]        sel_ff,     sel_in;
   logic [IDLE_W-1:0] idle_ff,    idle_in;
   logic              edit_ff,    edit_in;

   logic [VALUE_W-1:0] cur [FIELD_COUNT];
   logic [VALUE_W-1:0] nxt [FIELD_COUNT];
   logic [7:0]         load_byte [FIELD_COUNT];
   logic [VALUE_W-1:0] sel_val;
   logic [VALUE_W-1:0] lo;
   logic [VALUE_W-1:0] hi;
   logic [VALUE_W-1:0] up_val;
   logic [VALUE_W-1:0] dn_val;
   logic [IDLE_W-1:0]  idle_inc;
   logic               done;

   always_comb begin
      cur[0] = year_ff;
      cur[1] = {3'b000, month_ff};
      cur[2] = {2'b00, day_ff};
      cur[3] = {4'b0000, weekday_ff};
      cur[4] = {2'b00, hour_ff};
      cur[5] = {1'b0, minute_ff};
      cur[6] = {1'b0, second_ff};

      load_byte[0] = item.load_year_bcd;
      load_byte[1] = item.load_month_day_bcd[15:8];
      load_byte[2] = item.load_month_day_bcd[7:0];
      load_byte[3] = item.load_weekday_hour_bcd[15:8];
      load_byte[4] = item.load_weekday_hour_bcd[7:0];
      load_byte[5] = item.load_minute_second_bcd[15:8];
      load_byte[6] = item.load_minute_second_bcd[7:0];

      unique case (sel_ff)
         FIELD_YEAR:    sel_val = cur[0];
         FIELD_MONTH:   sel_val = cur[1];
         FIELD_DAY:     sel_val = cur[2];
         FIELD_WEEKDAY: sel_val = cur[3];
         FIELD_HOUR:    sel_val = cur[4];
         FIELD_MINUTE:  sel_val = cur[5];
         FIELD_SECOND:  sel_val = cur[6];
         default:       sel_val = '0;
      endcase

      lo     = field_low(sel_ff);
      hi     = field_high(sel_ff);
      up_val = (sel_val >= hi) ? lo : sel_val + 7'd1;
      dn_val = (sel_val <= lo) ? hi : sel_val - 7'd1;

      idle_inc = idle_ff + {{(IDLE_W-1){1'b0}}, 1'b1};

      for (int i = 0; i < FIELD_COUNT; i++) begin
         nxt[i] = cur[i];
      end
      sel_in  = sel_ff;
      idle_in = idle_ff;
      edit_in = edit_ff;
      done    = 1'b0;

      if (step_en) begin
         if (item.kind == KIND_START) begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
               nxt[i] = load_value(3'(i), load_byte[i]);
            end
            sel_in  = FIELD_YEAR;
            idle_in = '0;
            edit_in = 1'b1;
         end else if (edit_ff) begin
            if (idle_inc > {1'b0, timeout_limit}) begin
               idle_in = '0;
               done    = 1'b1;
            end else begin
               idle_in = idle_inc;
            end
            unique case (item.kind)
               KIND_UP:   nxt[sel_ff] = up_val;
               KIND_DOWN: nxt[sel_ff] = dn_val;
               KIND_ENTER: begin
                  if (sel_ff == FIELD_SECOND) begin
                     sel_in = FIELD_YEAR;
                     done   = 1'b1;
                  end else begin
                     sel_in = sel_ff + 3'd1;
                  end
               end
               default: ;
            endcase
            if (done) begin
               edit_in = 1'b0;
            end
         end
      end

      year_in    = nxt[0];
      month_in   = nxt[1][3:0];
      day_in     = nxt[2][4:0];
      weekday_in = nxt[3][2:0];
      hour_in    = nxt[4][4:0];
      minute_in  = nxt[5][5:0];
      second_in  = nxt[6][5:0];
   end

   always_comb begin
      logic [7:0] year_b;
      logic [7:0] month_b;
      logic [7:0] day_b;
      logic [7:0] weekday_b;
      logic [7:0] hour_b;
      logic [7:0] minute_b;
      logic [7:0] second_b;
      year_b    = bin_to_bcd(nxt[0]);
      month_b   = bin_to_bcd(nxt[1]);
      day_b     = bin_to_bcd(nxt[2]);
      weekday_b = bin_to_bcd(nxt[3]);
      hour_b    = bin_to_bcd(nxt[4]);
      minute_b  = bin_to_bcd(nxt[5]);
      second_b  = bin_to_bcd(nxt[6]);
      result.year_bcd          = year_b;
      result.month_day_bcd     = {month_b[4:0], day_b};
      result.weekday_hour_bcd  = {weekday_b[2:0], hour_b};
      result.minute_second_bcd = {minute_b[6:0], second_b};
      result.field_selected    = sel_in;
      result.session_active    = edit_in;
      result.finished          = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff    <= '0;
         month_ff   <= 4'd1;
         day_ff     <= 5'd1;
         weekday_ff <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         sel_ff     <= FIELD_YEAR;
         idle_ff    <= '0;
         edit_ff    <= 1'b0;
      end else begin
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         weekday_ff <= weekday_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         sel_ff     <= sel_in;
         idle_ff    <= idle_in;
         edit_ff    <= edit_in;
      end
   end

endmodule
